>>> rtl/lcf_pkg.sv
// Package for the linear convolution FIR unit.
// Shared widths, types, op codes, controller/datapath command structs.
// No dependencies.
package lcf_pkg;

    localparam int MAX_TAPS     = 32;
    localparam int SAMPLE_BITS  = 16;
    localparam int OUT_BITS     = 37;
    localparam int PROD_BITS    = 2 * SAMPLE_BITS;
    localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);
    localparam int TAP_CNT_BITS = 6;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [TAP_CNT_BITS-1:0] TAP_COUNT_RESET = TAP_CNT_BITS'(MAX_TAPS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [OUT_BITS-1:0]    acc_t;
    typedef logic [TAP_IDX_BITS-1:0]       tap_idx_t;
    typedef logic [TAP_CNT_BITS-1:0]       tap_cnt_t;

    typedef struct packed {
        logic     coef_we;
        logic     shift_in;
        logic     shift_zero;
        logic     clear_hist;
        logic     issue;
        logic     issue_first;
        logic     issue_last;
        tap_idx_t issue_idx;
        logic     load_out;
        logic     out_last;
    } lcf_cmd_t;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } lcf_status_t;

    // taps in use: 0 acts as 1, anything above MAX_TAPS acts as MAX_TAPS
    function automatic tap_cnt_t clamp_taps(tap_cnt_t raw);
        tap_cnt_t t;
        t = raw;
        if (raw == '0)
        begin
            t = TAP_CNT_BITS'(1);
        end
        else if (raw > TAP_CNT_BITS'(MAX_TAPS))
        begin
            t = TAP_CNT_BITS'(MAX_TAPS);
        end
        return t;
    endfunction

endpackage

>>> rtl/lcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lcf_datapath.sv
// Datapath: sample delay line, coefficient RAM, pipelined MAC, output register.
// Depends on lcf_pkg and lcf_ram.
module lcf_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcf_pkg::lcf_cmd_t       cmd,
    output lcf_pkg::lcf_status_t    status,
    input  logic [4:0]              coef_index,
    input  logic signed [15:0]      value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [36:0]      out_value,
    output logic                    out_last
);

    lcf_pkg::sample_t hist_reg [lcf_pkg::MAX_TAPS];

    logic [lcf_pkg::SAMPLE_BITS-1:0] coef_rdata;
    lcf_pkg::sample_t samp1_reg;
    logic             v1_reg;
    logic             first1_reg;
    logic             last1_reg;
    lcf_pkg::prod_t   prod_reg;
    logic             v2_reg;
    logic             first2_reg;
    logic             last2_reg;
    lcf_pkg::acc_t    acc_reg;
    logic             acc_done_reg;
    lcf_pkg::acc_t    out_value_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    lcf_ram #(
        .WIDTH (lcf_pkg::SAMPLE_BITS),
        .DEPTH (lcf_pkg::MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cmd.coef_we),
        .waddr (lcf_pkg::tap_idx_t'(coef_index)),
        .wdata (lcf_pkg::SAMPLE_BITS'(value)),
        .raddr (cmd.issue_idx),
        .rdata (coef_rdata)
    );

    // delay line, entry 0 newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < lcf_pkg::MAX_TAPS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (cmd.clear_hist)
        begin
            for (int k = 0; k < lcf_pkg::MAX_TAPS; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (cmd.shift_in)
        begin
            for (int k = lcf_pkg::MAX_TAPS - 1; k > 0; k--)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
            hist_reg[0] <= cmd.shift_zero ? '0 : lcf_pkg::sample_t'(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            acc_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg       <= cmd.issue;
            v2_reg       <= v1_reg;
            acc_done_reg <= v2_reg && last2_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        samp1_reg  <= hist_reg[cmd.issue_idx];
        first1_reg <= cmd.issue_first;
        last1_reg  <= cmd.issue_last;
        prod_reg   <= $signed(coef_rdata) * samp1_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        if (v2_reg)
        begin
            acc_reg <= first2_reg ? lcf_pkg::acc_t'(prod_reg)
                                  : acc_reg + lcf_pkg::acc_t'(prod_reg);
        end
        if (cmd.load_out)
        begin
            out_value_reg <= acc_reg;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign status.acc_done = acc_done_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/lcf_ctrl.sv
// Controller: sequences loads, the per-output tap walk and the tail flush.
// Depends on lcf_pkg.
module lcf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic                    last_sample,
    input  lcf_pkg::tap_cnt_t       taps,
    input  lcf_pkg::lcf_status_t    status,
    output lcf_pkg::lcf_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    lcf_pkg::tap_idx_t j_reg;
    lcf_pkg::tap_idx_t j_next;
    lcf_pkg::tap_idx_t f_reg;
    lcf_pkg::tap_idx_t f_next;
    logic              flush_reg;
    logic              flush_next;
    lcf_pkg::tap_cnt_t taps_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            f_reg     <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            f_reg     <= f_next;
            flush_reg <= flush_next;
        end
    end

    assign taps_m1 = taps - lcf_pkg::TAP_CNT_BITS'(1);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        f_next     = f_reg;
        flush_next = flush_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.issue_idx = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == lcf_pkg::OP_LOAD)
                    begin
                        cmd.coef_we = 1'b1;
                    end
                    else
                    begin
                        cmd.shift_in = 1'b1;
                        flush_next   = last_sample;
                        f_next       = '0;
                        j_next       = '0;
                        state_next   = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.issue       = 1'b1;
                cmd.issue_first = (j_reg == '0);
                cmd.issue_last  = ({1'b0, j_reg} == taps_m1);
                if (cmd.issue_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (status.acc_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = flush_reg && ({1'b0, f_reg} == taps_m1);
                    if (flush_reg && !cmd.out_last)
                    begin
                        // tail: feed a zero and walk the taps again
                        cmd.shift_in   = 1'b1;
                        cmd.shift_zero = 1'b1;
                        f_next         = f_reg + 1'b1;
                        j_next         = '0;
                        state_next     = S_MAC;
                    end
                    else
                    begin
                        cmd.clear_hist = flush_reg;
                        flush_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/linear_convolution_fir_unit.sv
// Top level of the linear convolution FIR unit: APB register, controller, datapath.
// Depends on lcf_pkg, lcf_ctrl, lcf_datapath (and lcf_ram through it).
//
// A coefficient load (op 0) gives no result. A sample (op 1) gives one Q7.30
// result: one shared 16x16 multiply-accumulate walks the taps one per cycle,
// reading the coefficient RAM port and the delay line, then its pipeline drains
// through the read, product and accumulator registers and the sum is loaded into
// the output register. The next request is taken in the cycle after that load,
// so a sample is not taken before the previous one is through. A sample with
// last_sample set adds tap_count-1 tail results, the final one flagged by
// out_last, and leaves the delay line cleared. A new request is taken once the
// previous result sits in the output register, even if it has not been taken
// yet; a result that is still waiting there holds back the next load.
// tap_count lives at address 0 (reset 32; 0 acts as 1, above 32 as 32).
module linear_convolution_fir_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [4:0]         coef_index,
    input  logic signed [15:0] value,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [36:0] out_value,
    output logic               out_last
);

    lcf_pkg::tap_cnt_t    tap_count_reg;
    lcf_pkg::lcf_cmd_t    cmd;
    lcf_pkg::lcf_status_t status;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= lcf_pkg::TAP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            tap_count_reg <= pwdata[lcf_pkg::TAP_CNT_BITS-1:0];
        end
    end

    assign prdata = reg_sel ? 32'(tap_count_reg) : '0;

    lcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .last_sample (last_sample),
        .taps        (lcf_pkg::clamp_taps(tap_count_reg)),
        .status      (status),
        .cmd         (cmd)
    );

    lcf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .coef_index (coef_index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .out_last   (out_last)
    );

    a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !in_ready)
        else $error("MAC issue while taking requests");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        status.acc_done |-> !cmd.issue && !cmd.shift_in)
        else $error("MAC busy when sum completes");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef_we |-> !cmd.issue && !cmd.load_out)
        else $error("coefficient write during tap walk");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for linear_convolution_fir_unit: coefficient loads,
// sample streams, tail flushes and tap_count settings checked against a predictor.
// Depends on lcf_pkg and the RTL of linear_convolution_fir_unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_TAP_COUNT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;
    localparam int         STALL_LIMIT    = 4000;
    localparam int         DRAIN_CYCLES   = 60;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         RANDOM_ITEMS   = 330;
    localparam longint     OUT_MAX        = (longint'(1) <<< (lcf_pkg::OUT_BITS - 1)) - 1;
    localparam longint     OUT_MIN        = -OUT_MAX - 1;

    typedef struct {
        lcf_pkg::acc_t sum;
        logic          last_flag;
    } conv_output_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [4:0]         coef_index;
    logic signed [15:0] value;
    logic               last_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [36:0] out_value;
    logic               out_last;

    lcf_pkg::sample_t  model_coefs [lcf_pkg::MAX_TAPS];
    lcf_pkg::sample_t  model_hist [lcf_pkg::MAX_TAPS];
    lcf_pkg::tap_cnt_t model_taps = lcf_pkg::TAP_COUNT_RESET;
    conv_output_t      pending_outputs [$];

    int error_count   = 0;
    int idle_cycles   = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;

    linear_convolution_fir_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coef_index  (coef_index),
        .value       (value),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .out_last    (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic lcf_pkg::sample_t rand_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return lcf_pkg::sample_t'($urandom());
        endcase
    endfunction

    function automatic void shift_history(input lcf_pkg::sample_t s);
        for (int k = lcf_pkg::MAX_TAPS - 1; k > 0; k--)
        begin
            model_hist[k] = model_hist[k - 1];
        end
        model_hist[0] = s;
    endfunction

    function automatic lcf_pkg::acc_t tap_sum(input int taps);
        longint acc;
        acc = 0;
        for (int j = 0; j < taps; j++)
        begin
            acc += longint'(model_hist[j]) * longint'(model_coefs[j]);
        end
        if (acc > OUT_MAX)
        begin
            acc = OUT_MAX;
        end
        if (acc < OUT_MIN)
        begin
            acc = OUT_MIN;
        end
        return lcf_pkg::acc_t'(acc);
    endfunction

    // state update and expected outputs for one accepted request
    task automatic convolve_request(input logic op_i, input lcf_pkg::tap_idx_t idx,
                                    input lcf_pkg::sample_t val, input logic last_i);
        int           taps;
        conv_output_t entry;
        if (op_i == lcf_pkg::OP_LOAD)
        begin
            model_coefs[idx] = val;
        end
        else
        begin
            taps = (model_taps == 0) ? 1 :
                   (model_taps > lcf_pkg::MAX_TAPS) ? lcf_pkg::MAX_TAPS : int'(model_taps);
            shift_history(val);
            entry.sum       = tap_sum(taps);
            entry.last_flag = last_i && (taps == 1);
            pending_outputs.push_back(entry);
            if (last_i)
            begin
                for (int f = 1; f < taps; f++)
                begin
                    shift_history('0);
                    entry.sum       = tap_sum(taps);
                    entry.last_flag = (f == taps - 1);
                    pending_outputs.push_back(entry);
                end
                for (int k = 0; k < lcf_pkg::MAX_TAPS; k++)
                begin
                    model_hist[k] = '0;
                end
            end
        end
    endtask

    task automatic send_request(input logic op_i, input logic [4:0] idx,
                                input lcf_pkg::sample_t val, input logic last_i);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 1) == 0)
        begin
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_i;
        coef_index  <= idx;
        value       <= val;
        last_sample <= last_i;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        convolve_request(op_i, idx, val, last_i);
    endtask

    // block idle: nothing pending and a margin for trailing loads
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_TAP_COUNT)
        begin
            model_taps = data[lcf_pkg::TAP_CNT_BITS-1:0];
        end
        // read back tap_count
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_TAP_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(model_taps))
        begin
            report_mismatch($sformatf("tap_count readback %0d, want %0d", prdata, model_taps));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_signal(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_request(lcf_pkg::OP_SAMPLE, 5'($urandom()), rand_value(), i == len - 1);
        end
    endtask

    task automatic test_coef_load();
        lcf_pkg::sample_t v;
        for (int i = 0; i < lcf_pkg::MAX_TAPS; i++)
        begin
            case (i)
                0: v = 16'sh7fff;
                1: v = 16'sh8000;
                2: v = 16'sh0000;
                3: v = 16'shffff;
                default: v = lcf_pkg::sample_t'($urandom());
            endcase
            // last flag set on odd loads: must be ignored
            send_request(lcf_pkg::OP_LOAD, 5'(i), v, i[0]);
        end
        settle();
    endtask

    task automatic test_reset_taps();
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh7fff, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd31, 16'sh8000, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh0000, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd31, 16'shffff, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh0001, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh8000, 1'b1);
        settle();
    endtask

    task automatic test_tap_extremes();
        cfg_write(ADDR_TAP_COUNT, 32'd1);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh8000, 1'b1);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh7fff, 1'b0);
        send_request(lcf_pkg::OP_SAMPLE, 5'd0, 16'sh7fff, 1'b1);
        settle();
        cfg_write(ADDR_TAP_COUNT, 32'd0);
        send_signal(2);
        settle();
        cfg_write(ADDR_TAP_COUNT, 32'd63);
        send_signal(2);
        settle();
        cfg_write(ADDR_TAP_COUNT, 32'd33);
        send_signal(1);
        settle();
        cfg_write(ADDR_TAP_COUNT, 32'hffff_ffc2);
        send_signal(2);
        settle();
        // unmapped register must leave tap_count alone
        cfg_write(ADDR_UNMAPPED, 32'd5);
        send_signal(2);
        settle();
    endtask

    task automatic test_backpressure();
        cfg_write(ADDR_TAP_COUNT, 32'd3);
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 500;
        for (int i = 0; i < 40; i++)
        begin
            send_request(lcf_pkg::OP_SAMPLE, 5'($urandom()), rand_value(), (i % 10) == 9);
        end
        settle();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_signals();
        int          sent;
        int          len;
        logic [5:0]  taps;
        logic [31:0] word;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0: taps = 6'd32;
                1: taps = 6'd0;
                2: taps = 6'($urandom_range(33, 63));
                3, 4: taps = 6'($urandom_range(9, 31));
                default: taps = 6'($urandom_range(1, 8));
            endcase
            word = {26'd0, taps};
            if ($urandom_range(0, 3) == 0)
            begin
                word = ($urandom() & 32'hffff_ffc0) | word;
            end
            cfg_write(ADDR_TAP_COUNT, word);
            repeat ($urandom_range(1, 3))
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_request(lcf_pkg::OP_LOAD, 5'($urandom()), rand_value(),
                                     1'($urandom()));
                        sent++;
                    end
                    // an occasional signal is left open and runs on into the next phase
                    send_request(lcf_pkg::OP_SAMPLE, 5'($urandom()), rand_value(),
                                 (i == len - 1) && ($urandom_range(0, 9) != 0));
                    sent++;
                end
            end
        end
        settle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else if (!rx_idle_on || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_outputs
        conv_output_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output %0d last %0b", out_value, out_last));
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (out_value !== want.sum)
                begin
                    report_mismatch($sformatf("out_value %0d, want %0d", out_value, want.sum));
                end
                if (out_last !== want.last_flag)
                begin
                    report_mismatch($sformatf("out_last %0b, want %0b", out_last, want.last_flag));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= ADDR_TAP_COUNT;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        op          <= lcf_pkg::OP_LOAD;
        coef_index  <= '0;
        value       <= '0;
        last_sample <= 1'b0;
        for (int k = 0; k < lcf_pkg::MAX_TAPS; k++)
        begin
            model_coefs[k] = '0;
            model_hist[k]  = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coef_load();
        test_reset_taps();
        test_tap_extremes();
        test_backpressure();
        test_random_signals();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
